// ===== rtl/etfi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escape-time fractal iterator package
// Shared payload types, sequencer states, register indexes and fixed-point
// helpers for the Q24.40 datapath.
// ----------------------------------------------------------------------------
package etfi_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register index, taken from paddr bit 2
  localparam logic REG_C_REAL = 1'b0;
  localparam logic REG_C_IMAG = 1'b1;

  localparam logic [31:0] C_REAL_RESET = 32'h1000_0000;
  localparam logic [31:0] C_IMAG_RESET = 32'h0000_0000;

  // 0.25 and 1.0 at Q.28, 2^52 (1/16 at Q.56)
  localparam logic [63:0] QUARTER_Q28  = 64'h0000_0000_0400_0000;
  localparam logic [63:0] ONE_Q28      = 64'h0000_0000_1000_0000;
  localparam logic [63:0] BULB_LIMIT   = 64'h0010_0000_0000_0000;
  localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] point_real;
    logic signed [31:0] point_imag;
    logic               julia_mode;
  } point_t;

  typedef struct packed {
    logic [8:0]  iteration_count;
    logic [63:0] final_magnitude_sq;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SC_Y2,
    ST_SC_AA,
    ST_SC_QS,
    ST_SC_BB,
    ST_SQ_R,
    ST_SQ_I,
    ST_CHECK,
    ST_CROSS
  } state_e;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

  // Q4.28 to Q24.40 with sign extension
  function automatic logic [63:0] to_q40(input logic [31:0] v);
    to_q40 = {{20{v[31]}}, v, 12'd0};
  endfunction

  // square of a magnitude, back to Q24.40, saturating
  function automatic logic [63:0] sq_q40(input logic [127:0] p);
    sq_q40 = (p[127:104] != 24'd0) ? ALL_ONES : p[103:40];
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add64 = s[64] ? ALL_ONES : s[63:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/etfi_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared 64x64 magnitude multiplier
// Forms the 128-bit product from four 32x32 partial products, one per cycle,
// each registered before it is accumulated. done_o pulses with the product.
// ----------------------------------------------------------------------------
module etfi_mul
  import etfi_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [63:0]  op_a_i,
  input  wire logic [63:0]  op_b_i,
  output logic              done_o,
  output logic [127:0]      prod_o
);

  logic [63:0]  a_q, b_q;
  logic [63:0]  pp_q, pp_d;
  logic [1:0]   sh_q, sh_d;
  logic [127:0] acc_q, acc_d;
  logic [2:0]   step_q, step_d;
  logic         run_q, run_d;
  logic         done_q, done_d;
  logic [31:0]  a_part, b_part;
  logic [127:0] term;

  always_comb begin
    a_part = step_q[1] ? a_q[63:32] : a_q[31:0];
    b_part = step_q[0] ? b_q[63:32] : b_q[31:0];
    pp_d   = 64'(a_part) * 64'(b_part);
    sh_d   = 2'(step_q[1]) + 2'(step_q[0]);
    case (sh_q)
      2'd0:    term = {64'd0, pp_q};
      2'd1:    term = {32'd0, pp_q, 32'd0};
      2'd2:    term = {pp_q, 64'd0};
      default: term = 128'd0;
    endcase
  end

  always_comb begin
    run_d  = run_q;
    step_d = step_q;
    done_d = 1'b0;
    acc_d  = acc_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = 3'd0;
      acc_d  = 128'd0;
    end else if (run_q) begin
      // fold in the partial product from the previous step
      if (step_q != 3'd0) begin
        acc_d = acc_q + term;
      end
      if (step_q == 3'd4) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= 3'd0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= op_a_i;
      b_q <= op_b_i;
    end
    pp_q  <= pp_d;
    sh_q  <= sh_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

// ===== rtl/etfi_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the Julia constant, real and imaginary.
// ----------------------------------------------------------------------------
module etfi_cfg
  import etfi_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [31:0]           c_real_o,
  output logic      [31:0]           c_imag_o
);

  logic [31:0] c_real_q, c_real_d;
  logic [31:0] c_imag_q, c_imag_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    c_real_d = c_real_q;
    c_imag_d = c_imag_q;
    if (wr_en) begin
      case (paddr[2])
        REG_C_REAL: c_real_d = pwdata;
        REG_C_IMAG: c_imag_d = pwdata;
        default:    c_real_d = c_real_q;
      endcase
    end
    case (paddr[2])
      REG_C_REAL: prdata = c_real_q;
      REG_C_IMAG: prdata = c_imag_q;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_real_q <= C_REAL_RESET;
      c_imag_q <= C_IMAG_RESET;
    end else begin
      c_real_q <= c_real_d;
      c_imag_q <= c_imag_d;
    end
  end

  assign c_real_o = c_real_q;
  assign c_imag_o = c_imag_q;

endmodule

`default_nettype wire

// ===== rtl/escape_time_fractal_iterator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escape-time fractal iterator
// Mandelbrot / Julia escape-time iteration in Q24.40 on one shared
// multiplier under a small sequencer.
//
//   channel   handshake               payload
//   -------   ---------------------   ------------------
//   point     start_i / busy_o        point_i  (point_t)
//   result    res_valid_o (strobe)    res_o    (result_t)
//   config    APB psel/penable/pready paddr, pwdata, prdata
//
// A point is taken when start_i is high and busy_o is low; busy_o stays high
// until the cycle its result is strobed, and a new point may be taken in that
// cycle. Every multiply runs on the shared 64x64 unit as four 32x32 steps.
// One iteration is two squares, the escape check and the cross term; for a
// Mandelbrot point in [-2, 2) on both axes the bulb tests run first.
// Reset clears the sequencer and loads the Julia constant with 1.0 + 0i.
// The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator_top
  import etfi_pkg::*;
#(
  parameter int unsigned MAX_ITERATIONS = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire point_t                point_i,
  output logic                       res_valid_o,
  output result_t                    res_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned ITER_W = $clog2(MAX_ITERATIONS + 1);

  state_e        state_q, state_d;
  logic          wait_q, wait_d;
  logic [63:0]   zr_q, zr_d, zi_q, zi_d;
  logic [63:0]   cr_q, cr_d, ci_q, ci_d;
  logic [63:0]   sr_q, sr_d, si_q, si_d;
  logic [63:0]   y2_q, y2_d, q28_q, q28_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic          res_valid_q, res_valid_d;
  result_t       res_q, res_d;

  logic          mul_start, mul_done;
  logic [63:0]   mul_a, mul_b;
  logic [127:0]  mul_prod;
  logic [31:0]   c_real, c_imag;

  logic [63:0]   sum_sat, sx, sy, a_val, s_val, b_val, p_lo, lhs, r_val;
  logic          in_range, is_mul_state;

  etfi_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .c_real_o (c_real),
    .c_imag_o (c_imag)
  );

  etfi_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .op_a_i  (mul_a),
    .op_b_i  (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // datapath terms
  always_comb begin
    sum_sat  = sat_add64(sr_q, si_q);
    sx       = {{32{cr_q[43]}}, cr_q[43:12]};
    sy       = {{32{ci_q[43]}}, ci_q[43:12]};
    a_val    = sx - QUARTER_Q28;
    s_val    = q28_q + a_val;
    b_val    = sx + ONE_Q28;
    p_lo     = mul_prod[63:0];
    lhs      = s_val[63] ? (64'd0 - p_lo) : p_lo;
    r_val    = mul_prod[102:39];
    in_range = ((point_i.point_real[31:29] == 3'b000) ||
                (point_i.point_real[31:29] == 3'b111)) &&
               ((point_i.point_imag[31:29] == 3'b000) ||
                (point_i.point_imag[31:29] == 3'b111));
  end

  // shared multiplier operand select
  always_comb begin
    is_mul_state = 1'b1;
    mul_a        = 64'd0;
    mul_b        = 64'd0;
    case (state_q)
      ST_SC_Y2: begin mul_a = mag64(sy);    mul_b = mag64(sy);    end
      ST_SC_AA: begin mul_a = mag64(a_val); mul_b = mag64(a_val); end
      ST_SC_QS: begin mul_a = q28_q;        mul_b = mag64(s_val); end
      ST_SC_BB: begin mul_a = mag64(b_val); mul_b = mag64(b_val); end
      ST_SQ_R:  begin mul_a = mag64(zr_q);  mul_b = mag64(zr_q);  end
      ST_SQ_I:  begin mul_a = mag64(zi_q);  mul_b = mag64(zi_q);  end
      ST_CROSS: begin mul_a = mag64(zr_q);  mul_b = mag64(zi_q);  end
      default:  is_mul_state = 1'b0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    wait_d      = wait_q;
    zr_d        = zr_q;
    zi_d        = zi_q;
    cr_d        = cr_q;
    ci_d        = ci_q;
    sr_d        = sr_q;
    si_d        = si_q;
    y2_d        = y2_q;
    q28_d       = q28_q;
    iter_d      = iter_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mul_start   = 1'b0;

    // issue once on entry, then wait for the product
    if (is_mul_state && !wait_q) begin
      mul_start = 1'b1;
      wait_d    = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          iter_d = '0;
          if (point_i.julia_mode) begin
            zr_d    = to_q40(point_i.point_real);
            zi_d    = to_q40(point_i.point_imag);
            cr_d    = to_q40(c_real);
            ci_d    = to_q40(c_imag);
            state_d = ST_SQ_R;
          end else begin
            zr_d    = 64'd0;
            zi_d    = 64'd0;
            cr_d    = to_q40(point_i.point_real);
            ci_d    = to_q40(point_i.point_imag);
            state_d = in_range ? ST_SC_Y2 : ST_SQ_R;
          end
        end
      end
      ST_SC_Y2: begin
        if (wait_q && mul_done) begin
          wait_d  = 1'b0;
          y2_d    = p_lo;
          state_d = ST_SC_AA;
        end
      end
      ST_SC_AA: begin
        if (wait_q && mul_done) begin
          wait_d  = 1'b0;
          q28_d   = (p_lo + y2_q) >> 28;
          state_d = ST_SC_QS;
        end
      end
      ST_SC_QS: begin
        if (wait_q && mul_done) begin
          wait_d = 1'b0;
          // main cardioid
          if ($signed(lhs) < $signed({2'b00, y2_q[63:2]})) begin
            res_valid_d = 1'b1;
            res_d       = '{iteration_count: 9'(MAX_ITERATIONS),
                            final_magnitude_sq: 64'd0};
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_SC_BB;
          end
        end
      end
      ST_SC_BB: begin
        if (wait_q && mul_done) begin
          wait_d = 1'b0;
          // period-2 bulb
          if ((p_lo + y2_q) < BULB_LIMIT) begin
            res_valid_d = 1'b1;
            res_d       = '{iteration_count: 9'(MAX_ITERATIONS),
                            final_magnitude_sq: 64'd0};
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_SQ_R;
          end
        end
      end
      ST_SQ_R: begin
        if (wait_q && mul_done) begin
          wait_d  = 1'b0;
          sr_d    = sq_q40(mul_prod);
          state_d = ST_SQ_I;
        end
      end
      ST_SQ_I: begin
        if (wait_q && mul_done) begin
          wait_d  = 1'b0;
          si_d    = sq_q40(mul_prod);
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if ((iter_q < ITER_W'(MAX_ITERATIONS)) && (sum_sat[63:56] == 8'd0)) begin
          state_d = ST_CROSS;
        end else begin
          res_valid_d = 1'b1;
          res_d       = '{iteration_count: 9'(iter_q),
                          final_magnitude_sq: sum_sat};
          state_d     = ST_IDLE;
        end
      end
      ST_CROSS: begin
        if (wait_q && mul_done) begin
          wait_d  = 1'b0;
          zi_d    = ((zr_q[63] ^ zi_q[63]) ? (64'd0 - r_val) : r_val) + ci_q;
          zr_d    = sr_q - si_q + cr_q;
          iter_d  = iter_q + ITER_W'(1);
          state_d = ST_SQ_R;
        end
      end
      default: begin
        state_d = ST_IDLE;
        wait_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wait_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wait_q      <= wait_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zr_q   <= zr_d;
    zi_q   <= zi_d;
    cr_q   <= cr_d;
    ci_q   <= ci_d;
    sr_q   <= sr_d;
    si_q   <= si_d;
    y2_q   <= y2_d;
    q28_q  <= q28_d;
    iter_q <= iter_d;
    res_q  <= res_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTH
  a_res_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy_o)
    else $error("result strobe while busy");

  a_res_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("transfer accepted without going busy");

  a_mul_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (wait_q && busy_o))
    else $error("multiplier product with no pending request");
`endif

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time fractal iterator testbench
// Drives Mandelbrot and Julia points through the start/busy port, loads
// several Julia constants over APB, and checks every result strobe against
// a fixed-point prediction of the escape-time loop computed on acceptance.
// ----------------------------------------------------------------------------
import etfi_pkg::*;

class escape_scoreboard;
  int unsigned iter_limit;
  logic [31:0] c_real;
  logic [31:0] c_imag;
  result_t     awaited[$];
  int unsigned failures;

  function new(int unsigned limit);
    iter_limit = limit;
    c_real     = C_REAL_RESET;
    c_imag     = C_IMAG_RESET;
    failures   = 0;
  endfunction

  function void flag(string msg);
    failures++;
    if (failures <= 10) $display("%0t ns: mismatch: %s", $time, msg);
  endfunction

  // Q4.28 to Q24.40
  function logic [63:0] widen(logic [31:0] v);
    return {{20{v[31]}}, v, 12'd0};
  endfunction

  function logic [63:0] abs64(logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function logic [63:0] square_sat(logic [63:0] v);
    logic [127:0] p;
    logic [63:0]  m;
    m = abs64(v);
    p = {64'd0, m} * {64'd0, m};
    return (p[127:104] != 24'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[103:40];
  endfunction

  // 2*a*b on magnitudes, truncated toward zero, then signed
  function logic [63:0] twice_cross(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    logic [63:0]  r;
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    r = p[102:39];
    return (a[63] ^ b[63]) ? (64'd0 - r) : r;
  endfunction

  function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  // main cardioid or period-2 bulb, only inside [-2, 2) on both axes
  function bit in_bulbs(logic [31:0] xr, logic [31:0] yr);
    longint x, y, y2, a, q, s, b;
    x = longint'($signed(xr));
    y = longint'($signed(yr));
    if (x < -64'sh2000_0000 || x >= 64'sh2000_0000 ||
        y < -64'sh2000_0000 || y >= 64'sh2000_0000) return 1'b0;
    y2 = y * y;
    a  = x - $signed(QUARTER_Q28);
    q  = (a * a + y2) >>> 28;
    s  = q + a;
    if (q * s < (y2 >>> 2)) return 1'b1;
    b = x + $signed(ONE_Q28);
    return (b * b + y2) < $signed(BULB_LIMIT);
  endfunction

  function result_t escape_time(point_t p);
    logic [63:0] zr, zi, cr, ci, sr, si;
    int unsigned n;
    result_t     r;
    n = 0;
    if (p.julia_mode) begin
      zr = widen(p.point_real);
      zi = widen(p.point_imag);
      cr = widen(c_real);
      ci = widen(c_imag);
    end else begin
      if (in_bulbs(p.point_real, p.point_imag)) begin
        r.iteration_count    = iter_limit[8:0];
        r.final_magnitude_sq = 64'd0;
        return r;
      end
      zr = 64'd0;
      zi = 64'd0;
      cr = widen(p.point_real);
      ci = widen(p.point_imag);
    end
    sr = square_sat(zr);
    si = square_sat(zi);
    // 65536.0 in Q24.40 is the escape radius squared
    while (n < iter_limit && add_sat(sr, si) < 64'h0100_0000_0000_0000) begin
      zi = twice_cross(zr, zi) + ci;
      zr = sr - si + cr;
      sr = square_sat(zr);
      si = square_sat(zi);
      n++;
    end
    r.iteration_count    = n[8:0];
    r.final_magnitude_sq = add_sat(sr, si);
    return r;
  endfunction

  function void note_point(point_t p);
    awaited.push_back(escape_time(p));
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (awaited.size() == 0) begin
      flag($sformatf("result with nothing pending: count=%0d mag=%h",
                     got.iteration_count, got.final_magnitude_sq));
      return;
    end
    want = awaited.pop_front();
    if (got.iteration_count !== want.iteration_count)
      flag($sformatf("iteration_count exp=%0d act=%0d",
                     want.iteration_count, got.iteration_count));
    if (got.final_magnitude_sq !== want.final_magnitude_sq)
      flag($sformatf("final_magnitude_sq exp=%h act=%h",
                     want.final_magnitude_sq, got.final_magnitude_sq));
  endfunction

  function void check_register(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) flag($sformatf("%s readback exp=%h act=%h", name, want, got));
  endfunction
endclass

module tb;
  localparam int unsigned ITER_LIMIT      = 256;
  localparam int unsigned ITEMS_PER_PHASE = 180;
  localparam int unsigned LAST_PHASE      = 7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  point_t                point_i;
  logic                  res_valid_o;
  result_t               res_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  escape_scoreboard board;

  escape_time_fractal_iterator_top #(
    .MAX_ITERATIONS(ITER_LIMIT)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .point_i    (point_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) board.check_result(res_o);
  end

  initial begin
    #400_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [31:0] q428(real v);
    return 32'($rtoi(v * 268435456.0));
  endfunction

  function automatic point_t mk_point(logic [31:0] re, logic [31:0] im, logic julia);
    point_t p;
    p.point_real = re;
    p.point_imag = im;
    p.julia_mode = julia;
    return p;
  endfunction

  function automatic point_t random_point();
    point_t      p;
    int unsigned pick;
    logic [31:0] base;
    pick         = $urandom_range(0, 99);
    p.point_real = $urandom;
    p.point_imag = $urandom;
    p.julia_mode = 1'b0;
    if (pick < 25) begin
      p.julia_mode = 1'($urandom_range(0, 1));
    end else if (pick < 60) begin
      // fold into [-2, 2) where the bulb tests apply
      p.point_real = {{3{p.point_real[31]}}, p.point_real[28:0]};
      p.point_imag = {{3{p.point_imag[31]}}, p.point_imag[28:0]};
    end else if (pick < 63) begin
      case ($urandom_range(0, 3))
        0:       base = q428(0.25);
        1:       base = q428(-0.75);
        2:       base = q428(-1.25);
        default: base = q428(-2.0);
      endcase
      p.point_real = base + 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      p.point_imag = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    end else if (pick < 80) begin
      p.julia_mode = 1'b1;
    end else begin
      p.julia_mode = 1'b1;
      p.point_real = {{3{p.point_real[31]}}, p.point_real[28:0]};
      p.point_imag = {{3{p.point_imag[31]}}, p.point_imag[28:0]};
    end
    return p;
  endfunction

  // hold start until the transfer, then, if may_idle, sometimes idle for a random burst
  task automatic send_point(input point_t p, input bit may_idle);
    int unsigned gap;
    start_i <= 1'b1;
    point_i <= p;
    do @(posedge clk_i); while (busy_o);
    board.note_point(p);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (board.awaited.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_julia_constant(input logic [31:0] re, input logic [31:0] im);
    logic [31:0] rd;
    apb_access(1'b1, REG_C_REAL, re, rd);
    apb_access(1'b1, REG_C_IMAG, im, rd);
    apb_access(1'b0, REG_C_REAL, 32'd0, rd);
    board.check_register("julia_c_real", re, rd);
    apb_access(1'b0, REG_C_IMAG, 32'd0, rd);
    board.check_register("julia_c_imag", im, rd);
    board.c_real = re;
    board.c_imag = im;
  endtask

  initial begin
    logic [31:0] rd;
    logic [31:0] re;
    logic [31:0] im;
    point_t      directed[$];
    rst_ni  <= 1'b0;
    start_i <= 1'b0;
    point_i <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    board = new(ITER_LIMIT);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_access(1'b0, REG_C_REAL, 32'd0, rd);
    board.check_register("julia_c_real after reset", C_REAL_RESET, rd);
    apb_access(1'b0, REG_C_IMAG, 32'd0, rd);
    board.check_register("julia_c_imag after reset", C_IMAG_RESET, rd);

    // cardioid, bulb, their edges, points bounded without a shortcut, extremes
    directed.push_back(mk_point(32'd0, 32'd0, 1'b0));
    directed.push_back(mk_point(q428(-1.0), 32'd0, 1'b0));
    directed.push_back(mk_point(q428(-0.5), q428(0.5), 1'b0));
    directed.push_back(mk_point(q428(-2.0), 32'd0, 1'b0));
    directed.push_back(mk_point(q428(2.0), 32'd0, 1'b0));
    directed.push_back(mk_point(32'h1FFF_FFFF, 32'h1FFF_FFFF, 1'b0));
    directed.push_back(mk_point(q428(0.25), 32'd0, 1'b0));
    directed.push_back(mk_point(q428(-0.75), 32'd0, 1'b0));
    directed.push_back(mk_point(q428(-1.25), 32'd0, 1'b0));
    directed.push_back(mk_point(q428(-0.1225), q428(0.745), 1'b0));
    directed.push_back(mk_point(q428(-1.9), 32'd0, 1'b0));
    directed.push_back(mk_point(32'd0, q428(-1.0), 1'b0));
    directed.push_back(mk_point(q428(1.0), q428(1.0), 1'b0));
    directed.push_back(mk_point(q428(0.3), q428(0.5), 1'b0));
    directed.push_back(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    directed.push_back(mk_point(32'h8000_0000, 32'h8000_0000, 1'b0));
    directed.push_back(mk_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    directed.push_back(mk_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    directed.push_back(mk_point(32'd0, 32'd0, 1'b1));
    directed.push_back(mk_point(q428(0.5), q428(0.5), 1'b1));
    directed.push_back(mk_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
    directed.push_back(mk_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
    foreach (directed[i]) send_point(directed[i], 1'b1);

    for (int ph = 0; ph <= LAST_PHASE; ph++) begin
      if (ph != 0) begin
        drain();
        case (ph)
          1: begin re = q428(-0.8);   im = q428(0.156); end
          2: begin re = 32'd0;        im = 32'd0;       end
          3: begin re = 32'h7FFF_FFFF; im = 32'h8000_0000; end
          4: begin re = 32'h8000_0000; im = 32'h7FFF_FFFF; end
          5: begin re = q428(-0.4);   im = q428(0.6);   end
          6: begin re = q428(0.285);  im = q428(0.01);  end
          default: begin re = $urandom; im = $urandom;  end
        endcase
        load_julia_constant(re, im);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_point(random_point(), ph != LAST_PHASE && (n % 64) < 44);
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (board.failures == 0 && board.awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
